### rtl/core/fapc_pkg.sv
package fapc_pkg;

   localparam int FAPC_PAYLOAD_BYTES = 12;
   localparam int FAPC_COMPARE_BITS  = 16;
   localparam int FAPC_CHANNELS      = 3;
   localparam int FAPC_COUNT_BITS    = $clog2(FAPC_PAYLOAD_BYTES);
   localparam int FAPC_Q_BITS        = 24;
   localparam int FAPC_ADDR_BITS     = 5;

   localparam logic [7:0] HDR_FIRST  = 8'h11;
   localparam logic [7:0] HDR_SECOND = 8'h22;
   localparam logic [7:0] HDR_THIRD  = 8'h33;
   localparam logic [7:0] TRL_FIRST  = 8'h33;
   localparam logic [7:0] TRL_SECOND = 8'h22;
   localparam logic [7:0] TRL_THIRD  = 8'h11;

   localparam logic [FAPC_Q_BITS-1:0] Q_FULL  = 24'(180 * 65536);
   localparam logic [31:0]            F32_180 = 32'h4334_0000;
   // ceil(2^32 / 180); exact floor division for dividends below 2^24
   localparam logic [24:0]            RECIP_180 = 25'd23860930;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_HDR1,
      ST_HDR2,
      ST_PAYLOAD,
      ST_TRL0,
      ST_TRL1,
      ST_TRL2
   } fapc_state_type;

   typedef enum logic [2:0] {
      CSR_BASE_FIRST,
      CSR_SPAN_FIRST,
      CSR_BASE_SECOND,
      CSR_SPAN_SECOND,
      CSR_BASE_THIRD,
      CSR_SPAN_THIRD
   } fapc_csr_type;

   // clamp an IEEE single to 0..180 degrees, truncated to unsigned Q8.16
   function automatic logic [FAPC_Q_BITS-1:0] angle_to_q(input logic [31:0] bits);
      logic [7:0]  expo;
      logic [23:0] mant;
      logic [7:0]  shift;
      logic [FAPC_Q_BITS-1:0] q;
      expo  = bits[30:23];
      mant  = {1'b1, bits[22:0]};
      shift = 8'd134 - expo;
      if (expo == 8'hFF && bits[22:0] != 23'd0) begin
         q = '0;
      end else if (bits[31]) begin
         q = '0;
      end else if (bits >= F32_180) begin
         q = Q_FULL;
      end else if (expo == 8'd0) begin
         q = '0;
      end else if (expo >= 8'd134) begin
         q = mant;
      end else if (shift >= 8'd24) begin
         q = '0;
      end else begin
         q = mant >> shift[4:0];
      end
      return q;
   endfunction

endpackage

### rtl/core/framed_angle_to_pwm_compare.sv
// channel | beat carries                        | handshake
// req     | rx_byte, one serial byte            | req_valid / req_ready
// rsp     | compare_first/second/third          | rsp_valid / rsp_ready
// csr     | six 16-bit registers at 4*i         | APB, pready tied high
//
// One byte taken per cycle while req_ready is high. After the closing trailer byte
// a result passes angle decode, span multiply, reciprocal multiply for /180, base
// add and saturate, each one register stage; the last is the output register.
// Reset (synchronous) puts the parser in header hunt and loads register defaults.
// req_ready drops only on the closing trailer byte while an earlier result
// still sits unclaimed in the output register.
module framed_angle_to_pwm_compare
   import fapc_pkg::*;
#(
   parameter int COMPARE_BITS = FAPC_COMPARE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_compare_first,
   output logic [15:0]               rsp_compare_second,
   output logic [15:0]               rsp_compare_third,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [FAPC_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam logic [16:0] LIMIT = 17'((1 << COMPARE_BITS) - 1);

   fapc_state_type             state_ff, state_in;
   logic [FAPC_COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]                 payload_ff [FAPC_PAYLOAD_BYTES];
   logic [15:0]                base_ff    [FAPC_CHANNELS];
   logic [15:0]                span_ff    [FAPC_CHANNELS];
   logic                       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [FAPC_Q_BITS-1:0]     q_ff       [FAPC_CHANNELS];
   logic [FAPC_Q_BITS-1:0]     t_ff       [FAPC_CHANNELS];
   logic [15:0]                off_ff     [FAPC_CHANNELS];
   logic [15:0]                compare_ff [FAPC_CHANNELS];
   logic                       rsp_valid_ff;

   logic        req_fire;
   logic        store_we;
   logic        frame_done;
   logic        csr_write;
   fapc_csr_type csr_index;

   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = fapc_csr_type'(csr_paddr[FAPC_ADDR_BITS-1:2]);
   assign csr_pready = 1'b1;

   // parser next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      if (req_fire) begin
         case (state_ff)
            ST_HUNT: begin
               state_in = (req_rx_byte == HDR_FIRST) ? ST_HDR1 : ST_HUNT;
            end
            ST_HDR1: begin
               state_in = (req_rx_byte == HDR_SECOND) ? ST_HDR2 : ST_HUNT;
            end
            ST_HDR2: begin
               state_in = (req_rx_byte == HDR_THIRD) ? ST_PAYLOAD : ST_HUNT;
               count_in = '0;
            end
            ST_PAYLOAD: begin
               if (count_ff == FAPC_COUNT_BITS'(FAPC_PAYLOAD_BYTES - 1)) begin
                  state_in = ST_TRL0;
               end
               count_in = count_ff + 1'b1;
            end
            ST_TRL0: begin
               state_in = (req_rx_byte == TRL_FIRST) ? ST_TRL1 : ST_HUNT;
            end
            ST_TRL1: begin
               state_in = (req_rx_byte == TRL_SECOND) ? ST_TRL2 : ST_HUNT;
            end
            ST_TRL2: begin
               state_in = ST_HUNT;
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   // parser outputs
   always_comb begin
      req_ready  = (state_ff != ST_TRL2) || !rsp_valid_ff || rsp_ready;
      store_we   = req_fire && (state_ff == ST_PAYLOAD);
      frame_done = req_fire && (state_ff == ST_TRL2) && (req_rx_byte == TRL_THIRD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         payload_ff[count_ff] <= req_rx_byte;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff[0] <= 16'd176;
         span_ff[0] <= 16'd21;
         base_ff[1] <= 16'd177;
         span_ff[1] <= 16'd16;
         base_ff[2] <= 16'd179;
         span_ff[2] <= 16'd13;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE_FIRST:  base_ff[0] <= csr_pwdata[15:0];
            CSR_SPAN_FIRST:  span_ff[0] <= csr_pwdata[15:0];
            CSR_BASE_SECOND: base_ff[1] <= csr_pwdata[15:0];
            CSR_SPAN_SECOND: span_ff[1] <= csr_pwdata[15:0];
            CSR_BASE_THIRD:  base_ff[2] <= csr_pwdata[15:0];
            CSR_SPAN_THIRD:  span_ff[2] <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_BASE_FIRST:  csr_prdata = {16'd0, base_ff[0]};
         CSR_SPAN_FIRST:  csr_prdata = {16'd0, span_ff[0]};
         CSR_BASE_SECOND: csr_prdata = {16'd0, base_ff[1]};
         CSR_SPAN_SECOND: csr_prdata = {16'd0, span_ff[1]};
         CSR_BASE_THIRD:  csr_prdata = {16'd0, base_ff[2]};
         CSR_SPAN_THIRD:  csr_prdata = {16'd0, span_ff[2]};
         default:         csr_prdata = '0;
      endcase
   end

   // conversion pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= frame_done;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   for (genvar ch = 0; ch < FAPC_CHANNELS; ch++) begin : g_lane
      logic [31:0]             bits;
      logic [39:0]             scaled;
      logic [48:0]             quot;
      logic [16:0]             sum;
      logic [FAPC_Q_BITS-1:0]  q_in;
      logic [FAPC_Q_BITS-1:0]  t_in;
      logic [15:0]             off_in;
      logic [15:0]             compare_in;

      assign bits = {payload_ff[4*ch+3], payload_ff[4*ch+2],
                     payload_ff[4*ch+1], payload_ff[4*ch]};
      assign q_in       = angle_to_q(bits);
      assign scaled     = 40'(q_ff[ch]) * 40'(span_ff[ch]);
      assign t_in       = scaled[39:16];
      assign quot       = 49'(t_ff[ch]) * 49'(RECIP_180);
      assign off_in     = quot[47:32];
      assign sum        = 17'(base_ff[ch]) + 17'(off_ff[ch]);
      assign compare_in = (sum > LIMIT) ? LIMIT[15:0] : sum[15:0];

      always_ff @(posedge clock) begin
         if (s1_valid_ff) begin
            q_ff[ch] <= q_in;
         end
         if (s2_valid_ff) begin
            t_ff[ch] <= t_in;
         end
         if (s3_valid_ff) begin
            off_ff[ch] <= off_in;
         end
         if (s4_valid_ff) begin
            compare_ff[ch] <= compare_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_compare_first  = compare_ff[0];
   assign rsp_compare_second = compare_ff[1];
   assign rsp_compare_third  = compare_ff[2];

`ifndef SYNTHESIS
   a_one_frame_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff}))
      else $error("two frames in the conversion pipeline");

   a_output_free: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (!rsp_valid_ff || rsp_ready))
      else $error("result lands on an unclaimed beat");

   a_q_in_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (q_ff[0] <= Q_FULL && q_ff[1] <= Q_FULL && q_ff[2] <= Q_FULL))
      else $error("decoded angle above 180 degrees");

   a_offset_in_span: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (off_ff[0] <= span_ff[0] && off_ff[1] <= span_ff[1]
                       && off_ff[2] <= span_ff[2]))
      else $error("offset exceeds span");

   a_count_in_payload: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAYLOAD) |-> (count_ff < FAPC_COUNT_BITS'(FAPC_PAYLOAD_BYTES)))
      else $error("payload count overrun");
`endif

endmodule
